// File: src/aes_pkg.sv
`default_nettype none
package aes_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic [0:0] {
        CFG_KEY_HI = 1'b0,
        CFG_KEY_LO = 1'b1
    } cfg_idx_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t rcon(input logic [3:0] rnd);
        byte_t r;
        case (rnd)
            4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
            4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
            4'd8: r = 8'h1b; 4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t get_byte(input block_t b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

endpackage
`default_nettype wire

// File: src/aes_round_cell.sv
`default_nettype none
module aes_round_cell
    import aes_pkg::*;
#(
    parameter logic [3:0] RoundIdx = 4'd0
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   adv,
    input  wire logic   valid_in,
    input  wire block_t state_in,
    input  wire block_t key_in,
    output logic        valid_out,
    output block_t      state_out,
    output block_t      key_out
);

    localparam bit LastRound = (RoundIdx == 4'(NumRounds - 1));

    block_t rk_next;
    block_t st_next;
    byte_t  sb [16];
    byte_t  sr [16];
    byte_t  mc [16];
    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;

    always_comb begin
        byte_t k [16];
        for (int i = 0; i < 16; i++) k[i] = get_byte(key_in, i);
        k[0] = k[0] ^ sbox(k[13]) ^ rcon(RoundIdx);
        k[1] = k[1] ^ sbox(k[14]);
        k[2] = k[2] ^ sbox(k[15]);
        k[3] = k[3] ^ sbox(k[12]);
        for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i - 4];
        for (int i = 0; i < 16; i++) rk_next[127 - 8 * i -: 8] = k[i];
    end

    always_comb begin
        for (int i = 0; i < 16; i++) sb[i] = sbox(get_byte(state_in, i));
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[r + 4 * c] = sb[r + 4 * ((c + r) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            byte_t all;
            all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c]   = sr[4*c]   ^ all ^ xtime(sr[4*c]   ^ sr[4*c+1]);
            mc[4*c+1] = sr[4*c+1] ^ all ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
            mc[4*c+2] = sr[4*c+2] ^ all ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
            mc[4*c+3] = sr[4*c+3] ^ all ^ xtime(sr[4*c+3] ^ sr[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            st_next[127 - 8 * i -: 8] = (LastRound ? sr[i] : mc[i])
                                      ^ rk_next[127 - 8 * i -: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            state_reg <= st_next;
            key_reg   <= rk_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule
`default_nettype wire

// File: src/aes128_block_encrypt_unit.sv
// AES-128 block encryption, ten round cells in a row.
// Key: write index 0 (key_hi, key bytes 0..7) and index 1 (key_lo, bytes
// 8..15) on the cfg channel; cfg_ready is always high, other indexes drop.
// Write the key only while no item is in flight.
// Input: s_valid/s_ready with plaintext_hi/lo; output: m_valid/m_ready with
// ciphertext_hi/lo. Byte 0 is the most significant byte of the hi word.
// Path: one input stage doing the initial key add, then one cell per
// round, each carrying its round key, up to m_valid.
// Throughput: one item per cycle unless stalled. Each cell holds its state
// and round key in registers, passed to the next cell as the row advances.
// Stall: when m_ready is low with a result waiting, the whole row holds
// and s_ready drops; empty stages hold too, so bubbles stay in place.
// Reset: clears all stage valid bits and the key registers to zero.
`default_nettype none
module aes128_block_encrypt_unit
    import aes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_plaintext_hi,
    input  wire logic [63:0] s_plaintext_lo,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_ciphertext_hi,
    output logic [63:0]      m_ciphertext_lo
);

    logic [63:0] key_hi_reg;
    logic [63:0] key_lo_reg;
    logic        in_valid_reg;
    block_t      in_state_reg;
    block_t      in_key_reg;
    logic        adv;

    logic   v   [NumRounds + 1];
    block_t st  [NumRounds + 1];
    block_t key [NumRounds + 1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY_HI: key_hi_reg <= cfg_data;
                CFG_KEY_LO: key_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold the row when the last stage has a result not taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_state_reg <= {s_plaintext_hi, s_plaintext_lo} ^ {key_hi_reg, key_lo_reg};
            in_key_reg   <= {key_hi_reg, key_lo_reg};
        end
    end

    assign v[0]   = in_valid_reg;
    assign st[0]  = in_state_reg;
    assign key[0] = in_key_reg;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_round_cell #(
            .RoundIdx(4'(g))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (v[g]),
            .state_in  (st[g]),
            .key_in    (key[g]),
            .valid_out (v[g + 1]),
            .state_out (st[g + 1]),
            .key_out   (key[g + 1])
        );
    end

    assign m_valid         = v[NumRounds];
    assign m_ciphertext_hi = st[NumRounds][127:64];
    assign m_ciphertext_lo = st[NumRounds][63:0];

endmodule
`default_nettype wire
